// ===== sv/tbes_pkg.sv =====
package tbes_pkg;

	localparam int NUM_TUBES_DEF = 8;
	localparam int DIGITS_DEF    = 10;
	localparam int LEVEL_MAX_DEF = 8;

	localparam logic [2:0] K_IDLE    = 3'd0;
	localparam logic [2:0] K_TICK    = 3'd0;
	localparam logic [2:0] K_SLEEP   = 3'd1;
	localparam logic [2:0] K_SET     = 3'd2;
	localparam logic [2:0] K_FADEIN  = 3'd3;
	localparam logic [2:0] K_FADEOUT = 3'd4;
	localparam logic [2:0] K_FOGIN   = 3'd5;
	localparam logic [2:0] K_FOGOUT  = 3'd6;

	localparam int LEVEL_W = 4;

endpackage

// ===== sv/tbes_ram.sv =====
module tbes_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/tube_brightness_effect_sequencer.sv =====
// Commands and ticks that cause no write are taken without leaving the idle state.
// A level write goes via ST_ONE to the output register; the next item waits until it is loaded.
// A fog step or fog-out start runs a read-modify-write sweep of the tube's digits through the level
// RAM (ST_URD then ST_UWR per digit), then a read-out sweep (ST_ERD then ST_EWR per digit).
// Reset clears all control state and the per-entry valid bits, so every level reads 0.
module tube_brightness_effect_sequencer
	import tbes_pkg::*;
#(
	parameter int NUM_TUBES = NUM_TUBES_DEF,
	parameter int DIGITS    = DIGITS_DEF,
	parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // tube[2:0], digit[6:3], value[22:7], zero pad
	input  logic [2:0]  s_axis_tuser,   // mode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // out_tube[2:0], out_digit[6:3], out_level[10:7],
	                                    // busy_res[11], zero pad
	output logic        m_axis_tlast    // last
);

	localparam int DEPTH = NUM_TUBES * DIGITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DIGITS + 1);
	localparam logic [4:0] NT = 5'(NUM_TUBES);
	localparam logic [4:0] ND = 5'(DIGITS);
	localparam logic [LEVEL_W-1:0] LM = LEVEL_W'(LEVEL_MAX);
	localparam logic [3:0] DLAST = 4'(DIGITS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ONE  = 3'd1;
	localparam logic [2:0] ST_URD  = 3'd2;
	localparam logic [2:0] ST_UWR  = 3'd3;
	localparam logic [2:0] ST_ERD  = 3'd4;
	localparam logic [2:0] ST_EWR  = 3'd5;

	logic [2:0]         state_q;
	logic [2:0]         kind_q;
	logic [2:0]         tube_q;
	logic [3:0]         digit_q;
	logic [15:0]        interval_q;
	logic [15:0]        elapsed_q;
	logic [LEVEL_W-1:0] fade_q;
	logic [LEVEL_W-1:0] one_lvl_q;
	logic               fill_q;
	logic [3:0]         d_q;
	logic [CW-1:0]      cnt_q;
	logic [DEPTH-1:0]   vld_q;
	logic               vld_s1;

	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;
	logic               m_tlast_q;

	logic [2:0]         in_mode;
	logic [2:0]         in_tube;
	logic [3:0]         in_digit;
	logic [15:0]        in_value;
	logic               in_acc;
	logic               out_free;
	logic               out_load;
	logic [15:0]        out_data;
	logic               out_last;

	logic [AW-1:0]      base;
	logic [AW-1:0]      addr_d;
	logic [AW-1:0]      addr_one;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [LEVEL_W-1:0] mem_wdata;
	logic               mem_re;
	logic [LEVEL_W-1:0] mem_rdata;
	logic [LEVEL_W-1:0] rd_level;

	logic [4:0]         inc;
	logic [LEVEL_W-1:0] upd_lvl;
	logic               upd_hit;
	logic [CW-1:0]      cnt_nxt;
	logic [15:0]        elapsed_inc;
	logic               cmd_ok;
	logic               d_last;

	assign in_mode  = s_axis_tuser;
	assign in_tube  = s_axis_tdata[2:0];
	assign in_digit = s_axis_tdata[6:3];
	assign in_value = s_axis_tdata[22:7];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign d_last        = (d_q == DLAST);

	assign base     = AW'(tube_q) * AW'(DIGITS);
	assign addr_d   = base + AW'(d_q);
	assign addr_one = base + AW'(digit_q);

	assign rd_level = vld_s1 ? mem_rdata : '0;

	assign mem_re    = (state_q == ST_URD) || (state_q == ST_ERD);
	assign mem_we    = (state_q == ST_UWR) || ((state_q == ST_ONE) && out_free);
	assign mem_waddr = (state_q == ST_UWR) ? addr_d : addr_one;
	assign mem_wdata = (state_q == ST_UWR) ? upd_lvl : one_lvl_q;

	tbes_ram #(
		.WIDTH(LEVEL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr_d),
		.rdata(mem_rdata)
	);

	always_comb begin
		inc     = {1'b0, rd_level} + 5'd1;
		upd_lvl = LM;
		upd_hit = 1'b0;
		if (fill_q) begin
			upd_lvl = LM;
		end else if (kind_q == K_FOGIN) begin
			if (inc >= {1'b0, LM}) begin
				upd_lvl = LM;
				upd_hit = 1'b1;
			end else begin
				upd_lvl = inc[LEVEL_W-1:0];
			end
		end else if (d_q == digit_q) begin
			upd_lvl = LM;
		end else begin
			upd_lvl = (rd_level != '0) ? rd_level - LEVEL_W'(1) : '0;
			upd_hit = (upd_lvl == '0);
		end
		cnt_nxt = cnt_q + CW'(upd_hit);
	end

	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		cmd_ok = (kind_q == K_IDLE) && (in_mode != K_TICK) && (in_mode <= K_FOGOUT);
		if (in_mode != K_SLEEP && {2'b0, in_tube} >= NT) begin
			cmd_ok = 1'b0;
		end
		if (in_mode != K_SLEEP && in_mode != K_FOGIN && {1'b0, in_digit} >= ND) begin
			cmd_ok = 1'b0;
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		out_last = 1'b0;
		if (state_q == ST_ONE) begin
			out_load = out_free;
			out_data = {4'b0, kind_q != K_IDLE, one_lvl_q, digit_q, tube_q};
			out_last = 1'b1;
		end else if (state_q == ST_EWR) begin
			out_load = out_free;
			out_data = {4'b0, kind_q != K_IDLE, rd_level, d_q, tube_q};
			out_last = d_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			vld_s1 <= vld_q[addr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= out_data;
			m_tlast_q  <= out_last;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= K_IDLE;
			tube_q     <= '0;
			digit_q    <= '0;
			interval_q <= '0;
			elapsed_q  <= '0;
			fade_q     <= '0;
			one_lvl_q  <= '0;
			fill_q     <= 1'b0;
			d_q        <= '0;
			cnt_q      <= '0;
			vld_q      <= '0;
		end else begin
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_mode == K_TICK && kind_q != K_IDLE) begin
						if (elapsed_inc < interval_q) begin
							elapsed_q <= elapsed_inc;
						end else begin
							elapsed_q <= '0;
							d_q       <= '0;
							cnt_q     <= '0;
							fill_q    <= 1'b0;
							unique case (kind_q)
								K_FADEIN: begin
									if (fade_q >= LM) begin
										fade_q    <= '0;
										one_lvl_q <= '0;
										kind_q    <= K_IDLE;
									end else begin
										fade_q    <= fade_q + LEVEL_W'(1);
										one_lvl_q <= fade_q + LEVEL_W'(1);
									end
									state_q <= ST_ONE;
								end
								K_FADEOUT: begin
									if (fade_q <= LEVEL_W'(1)) begin
										fade_q    <= '0;
										one_lvl_q <= '0;
										kind_q    <= K_IDLE;
									end else begin
										fade_q    <= fade_q - LEVEL_W'(1);
										one_lvl_q <= fade_q - LEVEL_W'(1);
									end
									state_q <= ST_ONE;
								end
								K_FOGIN, K_FOGOUT: begin
									state_q <= ST_URD;
								end
								default: begin
									kind_q <= K_IDLE;
								end
							endcase
						end
					end else if (in_acc && cmd_ok) begin
						elapsed_q  <= '0;
						interval_q <= in_value;
						d_q        <= '0;
						cnt_q      <= '0;
						if (in_mode != K_SLEEP) begin
							tube_q <= in_tube;
						end
						if (in_mode != K_SLEEP && in_mode != K_FOGIN) begin
							digit_q <= in_digit;
						end
						unique case (in_mode)
							K_SLEEP: begin
								kind_q <= K_SLEEP;
							end
							K_SET: begin
								interval_q <= '0;
								one_lvl_q  <= (in_value > 16'(LEVEL_MAX)) ? LM
								              : in_value[LEVEL_W-1:0];
								state_q    <= ST_ONE;
							end
							K_FADEIN: begin
								kind_q    <= K_FADEIN;
								fade_q    <= '0;
								one_lvl_q <= '0;
								state_q   <= ST_ONE;
							end
							K_FADEOUT: begin
								kind_q    <= K_FADEOUT;
								fade_q    <= LM;
								one_lvl_q <= LM;
								state_q   <= ST_ONE;
							end
							K_FOGIN: begin
								kind_q <= K_FOGIN;
							end
							default: begin
								kind_q  <= K_FOGOUT;
								fill_q  <= 1'b1;
								state_q <= ST_URD;
							end
						endcase
					end
				end
				ST_ONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_URD: begin
					state_q <= ST_UWR;
				end
				ST_UWR: begin
					cnt_q <= cnt_nxt;
					if (d_last) begin
						d_q     <= '0;
						state_q <= ST_ERD;
						if (!fill_q && kind_q == K_FOGIN && cnt_nxt >= CW'(DIGITS)) begin
							kind_q <= K_IDLE;
						end
						if (!fill_q && kind_q == K_FOGOUT && cnt_nxt >= CW'(DIGITS - 1)) begin
							kind_q <= K_IDLE;
						end
					end else begin
						d_q     <= d_q + 4'd1;
						state_q <= ST_URD;
					end
				end
				ST_ERD: begin
					state_q <= ST_EWR;
				end
				ST_EWR: begin
					if (out_free) begin
						if (d_last) begin
							d_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							d_q     <= d_q + 4'd1;
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result loaded over a waiting item");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, d_q} < ND))
		else $error("digit counter out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DIGITS))
		else $error("saturation count out of range");

	a_emit_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERD || state_q == ST_EWR) |-> !mem_we)
		else $error("store written during read-out");

	a_sweep_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_URD) |=> (state_q == ST_UWR) && mem_we)
		else $error("read-modify-write lost its write");
`endif

endmodule

// ===== verif/tube_brightness_effect_sequencer_test.sv =====
`timescale 1ns / 100ps

module tube_brightness_effect_sequencer_test
	import tbes_pkg::*;
;

	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef struct {
		logic [2:0] tube;
		logic [3:0] digit;
		logic [3:0] level;
		logic       busy;
		logic       last;
	} level_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	level_write_t pending_writes[$];
	int mismatches = 0;
	int applied_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit calm = 1'b0;

	logic [3:0]  level_mem [NUM_TUBES_DEF * DIGITS_DEF];
	logic [2:0]  fx_kind = K_IDLE;
	logic [2:0]  fx_tube = '0;
	logic [3:0]  fx_digit = '0;
	logic [15:0] fx_interval = '0;
	logic [15:0] fx_elapsed = '0;
	logic [3:0]  fx_fade = '0;

	tube_brightness_effect_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (level_mem[i])
			level_mem[i] = '0;
	end

	function automatic void emit_level(logic [3:0] lv);
		level_mem[fx_tube * DIGITS_DEF + fx_digit] = lv;
		pending_writes.push_back('{fx_tube, fx_digit, lv, fx_kind != K_IDLE, 1'b1});
	endfunction

	function automatic void emit_tube();
		for (int d = 0; d < DIGITS_DEF; d++)
			pending_writes.push_back('{fx_tube, 4'(d), level_mem[fx_tube * DIGITS_DEF + d],
				fx_kind != K_IDLE, d == DIGITS_DEF - 1});
	endfunction

	function automatic void step_effect();
		int base;
		int settled;
		logic [3:0] v;
		base = fx_tube * DIGITS_DEF;
		settled = 0;
		case (fx_kind)
			K_SLEEP: fx_kind = K_IDLE;
			K_FADEIN: begin
				if (fx_fade >= LEVEL_MAX_DEF) begin
					fx_fade = '0;
					fx_kind = K_IDLE;
				end else begin
					fx_fade++;
				end
				emit_level(fx_fade);
			end
			K_FADEOUT: begin
				if (fx_fade > 0)
					fx_fade--;
				if (fx_fade == 0)
					fx_kind = K_IDLE;
				emit_level(fx_fade);
			end
			K_FOGIN: begin
				for (int d = 0; d < DIGITS_DEF; d++) begin
					v = level_mem[base + d] + 4'd1;
					if (v >= LEVEL_MAX_DEF) begin
						v = 4'(LEVEL_MAX_DEF);
						settled++;
					end
					level_mem[base + d] = v;
				end
				if (settled >= DIGITS_DEF)
					fx_kind = K_IDLE;
				emit_tube();
			end
			K_FOGOUT: begin
				for (int d = 0; d < DIGITS_DEF; d++) begin
					if (d == fx_digit) begin
						level_mem[base + d] = 4'(LEVEL_MAX_DEF);
					end else begin
						if (level_mem[base + d] > 0)
							level_mem[base + d]--;
						if (level_mem[base + d] == 0)
							settled++;
					end
				end
				if (settled >= DIGITS_DEF - 1)
					fx_kind = K_IDLE;
				emit_tube();
			end
			default: fx_kind = K_IDLE;
		endcase
	endfunction

	task automatic apply_item(input logic [2:0] mode, input logic [2:0] tube,
		input logic [3:0] digit, input logic [15:0] value, output bit taken);
		taken = 1'b0;
		if (mode == K_TICK) begin
			if (fx_kind == K_IDLE)
				return;
			taken = 1'b1;
			if (fx_elapsed < 16'hFFFF)
				fx_elapsed++;
			if (fx_elapsed < fx_interval)
				return;
			fx_elapsed = '0;
			step_effect();
			return;
		end
		if (mode > K_FOGOUT || fx_kind != K_IDLE)
			return;
		if (mode != K_SLEEP && tube >= NUM_TUBES_DEF)
			return;
		if (mode != K_SLEEP && mode != K_FOGIN && digit >= DIGITS_DEF)
			return;
		taken = 1'b1;
		fx_elapsed = '0;
		fx_interval = value;
		if (mode != K_SLEEP) begin
			fx_tube = tube;
			if (mode != K_FOGIN)
				fx_digit = digit;
		end
		case (mode)
			K_SLEEP: fx_kind = K_SLEEP;
			K_SET: begin
				fx_interval = '0;
				emit_level((value > LEVEL_MAX_DEF) ? 4'(LEVEL_MAX_DEF) : value[3:0]);
			end
			K_FADEIN: begin
				fx_kind = K_FADEIN;
				fx_fade = '0;
				emit_level(fx_fade);
			end
			K_FADEOUT: begin
				fx_kind = K_FADEOUT;
				fx_fade = 4'(LEVEL_MAX_DEF);
				emit_level(fx_fade);
			end
			K_FOGIN: fx_kind = K_FOGIN;
			default: begin
				fx_kind = K_FOGOUT;
				for (int d = 0; d < DIGITS_DEF; d++)
					level_mem[fx_tube * DIGITS_DEF + d] = 4'(LEVEL_MAX_DEF);
				emit_tube();
			end
		endcase
	endtask

	task automatic send_item(input logic [2:0] mode, input logic [2:0] tube,
		input logic [3:0] digit, input logic [15:0] value);
		bit taken;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, value, digit, tube};
		s_axis_tuser <= mode;
		do
			@(posedge clk);
		while (!s_axis_tready);
		apply_item(mode, tube, digit, value, taken);
		if (taken)
			applied_items++;
		while (!calm && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic tick_until_idle();
		while (fx_kind != K_IDLE)
			send_item(K_TICK, 3'($urandom), 4'($urandom), 16'($urandom));
	endtask

	task automatic send_start();
		logic [2:0]  mode;
		logic [3:0]  digit;
		logic [15:0] value;
		mode = 3'($urandom_range(K_FOGOUT, K_SLEEP));
		if ($urandom_range(9) == 0)
			digit = 4'($urandom_range(15, DIGITS_DEF));
		else
			digit = 4'($urandom_range(DIGITS_DEF - 1));
		if (mode == K_SET) begin
			case ($urandom_range(2))
				0: value = 16'($urandom_range(LEVEL_MAX_DEF));
				1: value = 16'($urandom);
				default: value = 16'($urandom_range(65535, 65000));
			endcase
		end else if (mode == K_SLEEP && $urandom_range(19) == 0) begin
			value = 16'($urandom_range(400, 100));
		end else if ($urandom_range(9) == 0) begin
			value = 16'($urandom_range(12, 4));
		end else begin
			value = 16'($urandom_range(3));
		end
		send_item(mode, 3'($urandom_range(NUM_TUBES_DEF - 1)), digit, value);
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) m_axis_tready <= calm || ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : check_writes
		level_write_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected level write: tube %0d digit %0d level %0d",
					m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[10:7]);
				mismatches++;
			end else begin
				want = pending_writes.pop_front();
				check_field("out_tube", 16'(want.tube), 16'(m_axis_tdata[2:0]));
				check_field("out_digit", 16'(want.digit), 16'(m_axis_tdata[6:3]));
				check_field("out_level", 16'(want.level), 16'(m_axis_tdata[10:7]));
				check_field("busy_res", 16'(want.busy), 16'(m_axis_tdata[11]));
				check_field("last", 16'(want.last), 16'(m_axis_tlast));
			end
		end
	end

	task automatic test_ignored_items();
		send_item(K_TICK, 3'd7, 4'd15, 16'hFFFF);
		send_item(MODE_UNUSED, 3'd7, 4'd15, 16'hFFFF);
		send_item(K_SET, 3'd5, 4'd15, 16'hFFFF);
		send_item(K_FOGOUT, 3'd2, 4'd12, 16'd0);
	endtask

	task automatic test_set_digit();
		send_item(K_SET, 3'd7, 4'd9, 16'hFFFF);
		send_item(K_SET, 3'd0, 4'd0, 16'd0);
		send_item(K_SET, 3'd3, 4'd4, 16'(LEVEL_MAX_DEF + 1));
	endtask

	task automatic test_fade_out_while_busy();
		send_item(K_FADEOUT, 3'd7, 4'd9, 16'd0);
		send_item(K_FOGIN, 3'd1, 4'd0, 16'd0);
		tick_until_idle();
	endtask

	task automatic test_sleep();
		send_item(K_SLEEP, 3'd6, 4'd13, 16'd2);
		send_item(K_SET, 3'd1, 4'd1, 16'd3);
		tick_until_idle();
	endtask

	task automatic test_fog_in();
		send_item(K_FOGIN, 3'd3, 4'd15, 16'd0);
		tick_until_idle();
	endtask

	task automatic test_random_traffic(input int send_pct, input int stall_pct, input int n);
		int goal;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		goal = applied_items + n;
		while (applied_items < goal) begin
			calm = ($urandom_range(4) == 0);
			if ($urandom_range(9) == 0)
				send_item($urandom_range(1) ? K_TICK : MODE_UNUSED, 3'($urandom),
					4'($urandom), 16'($urandom));
			send_start();
			while (fx_kind != K_IDLE) begin
				if ($urandom_range(11) == 0)
					send_item(3'($urandom_range(MODE_UNUSED, K_SLEEP)), 3'($urandom),
						4'($urandom), 16'($urandom));
				else
					send_item(K_TICK, 3'($urandom), 4'($urandom), 16'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_items();
		test_set_digit();
		test_fade_out_while_busy();
		test_sleep();
		test_fog_in();
		test_random_traffic(0, 0, 65);
		test_random_traffic(85, 0, 60);
		test_random_traffic(0, 85, 60);
		test_random_traffic(27, 27, 65);
		s_axis_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4 * DIGITS_DEF + 8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
